/* rtl/archive_directory_parser_core_assert.svh */
// Assertion macros used by the archive directory parser walker.
`ifndef ARCHIVE_DIRECTORY_PARSER_CORE_ASSERT_SVH
`define ARCHIVE_DIRECTORY_PARSER_CORE_ASSERT_SVH

// Condition holds in the same cycle as the trigger.
`define ADP_ASSERT_IMP(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
		else $error("adp assertion failed");

// Condition holds in the cycle after the trigger.
`define ADP_ASSERT_NXT(label, clk, rst_n, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
		else $error("adp assertion failed");

`endif

/* rtl/adp_pkg.sv */
// Shared types and constants of the archive directory parser.
package adp_pkg;

	// Widths of the result fields.
	localparam int unsigned IDX_W  = 31;
	localparam int unsigned OFF_W  = 63;
	localparam int unsigned NLEN_W = 21;

	// Largest name length the block ever accepts.
	localparam logic [NLEN_W-1:0] NAME_LIMIT = 21'd1048576;

	// Byte counts of the header fields.
	localparam logic [3:0] SHORT_FIELD_BYTES = 4'd4;
	localparam logic [3:0] LONG_FIELD_BYTES  = 4'd8;

	// Parse phases.
	typedef enum logic [2:0] {
		PH_COUNT   = 3'd0,
		PH_NAMELEN = 3'd1,
		PH_NAME    = 3'd2,
		PH_DATALEN = 3'd3,
		PH_PAYLOAD = 3'd4,
		PH_DONE    = 3'd5
	} phase_t;

	// Result status codes.
	typedef enum logic [2:0] {
		ST_ENTRY     = 3'd0,
		ST_FINAL     = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NEG_COUNT = 3'd3,
		ST_BAD_NAME  = 3'd4,
		ST_BAD_DATA  = 3'd5,
		ST_TRUNC     = 3'd6
	} status_t;

	// One registered stream byte handed to the walker.
	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} adp_step_t;

endpackage

/* rtl/adp_stream_if.sv */
// Request channel carrying raw archive bytes.
interface adp_stream_if;
	import adp_pkg::*;

	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       stream_end;

	modport source (output valid, output data_byte, output stream_end, input ready);
	modport sink (input valid, input data_byte, input stream_end, output ready);
endinterface

/* rtl/adp_entry_if.sv */
// Request channel carrying directory descriptors and error reports.
interface adp_entry_if;
	import adp_pkg::*;

	logic              valid;
	logic              ready;
	status_t           status;
	logic [IDX_W-1:0]  entry_index;
	logic [OFF_W-1:0]  name_offset;
	logic [NLEN_W-1:0] name_length;
	logic [OFF_W-1:0]  payload_offset;
	logic [OFF_W-1:0]  data_length;

	modport source (
		output valid, output status, output entry_index, output name_offset,
		output name_length, output payload_offset, output data_length, input ready
	);
	modport sink (
		input valid, input status, input entry_index, input name_offset,
		input name_length, input payload_offset, input data_length, output ready
	);
endinterface

/* rtl/archive_directory_parser_core.sv */
// Top level of the archive directory parser.
// Bytes pass the input register stage, then the walker and its result register.
// Throughput: one stream byte per cycle; while a result waits in the output register
// and is not taken, the walker holds its byte and the input side stalls once full.
// Reset: arst_n clears the parse state and the result valid flag and sets
// max_name_length to 1048576; payload registers are not reset.
module archive_directory_parser_core (
	input  logic                       clk,
	input  logic                       arst_n,
	adp_stream_if.sink                 stream,
	adp_entry_if.source                entry,
	input  logic                       cfg_wr_en,
	input  logic [adp_pkg::NLEN_W-1:0] cfg_wr_data
);
	import adp_pkg::*;

	logic [NLEN_W-1:0] max_name_len_q;
	adp_step_t         step;
	logic              advance;

	// Name length limit register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_name_len_q <= NAME_LIMIT;
		end else if (cfg_wr_en) begin
			max_name_len_q <= cfg_wr_data;
		end
	end

	adp_in_stage u_in_stage (
		.clk     (clk),
		.arst_n  (arst_n),
		.stream  (stream),
		.advance (advance),
		.step    (step)
	);

	adp_walker u_walker (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (step),
		.max_name_len (max_name_len_q),
		.advance      (advance),
		.entry        (entry)
	);
endmodule

/* rtl/adp_in_stage.sv */
// Input register stage that captures one stream byte per cycle while the walker takes bytes.
module adp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	adp_stream_if.sink         stream,
	input  logic               advance,
	output adp_pkg::adp_step_t step
);
	import adp_pkg::*;

	logic       valid_s1;
	logic [7:0] data_s1;
	logic       last_s1;
	logic       take;

	// The stage frees up whenever the walker consumes its byte.
	assign stream.ready = !valid_s1 || advance;
	assign take         = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload needs no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			data_s1 <= stream.data_byte;
			last_s1 <= stream.stream_end;
		end
	end

	assign step.valid = valid_s1;
	assign step.data  = data_s1;
	assign step.last  = last_s1;
endmodule

/* rtl/adp_walker.sv */
// Directory walker: parse state, per-byte step logic and result register.
`include "archive_directory_parser_core_assert.svh"

module adp_walker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  adp_pkg::adp_step_t         step,
	input  logic [adp_pkg::NLEN_W-1:0] max_name_len,
	output logic                       advance,
	adp_entry_if.source                entry
);
	import adp_pkg::*;

	// Parse state.
	phase_t            phase_q;
	logic [2:0]        fcnt_q;
	logic [63:0]       shift_q;
	logic [IDX_W-1:0]  entries_q;
	logic [IDX_W-1:0]  cur_q;
	logic [OFF_W-1:0]  pos_q;
	logic [OFF_W-1:0]  skip_q;
	logic [OFF_W-1:0]  held_off_q;
	logic [NLEN_W-1:0] held_len_q;

	phase_t            phase_after;
	phase_t            phase_d;
	logic [2:0]        fcnt_d;
	logic [63:0]       shift_d;
	logic [IDX_W-1:0]  entries_d;
	logic [IDX_W-1:0]  cur_d;
	logic [OFF_W-1:0]  skip_d;
	logic [OFF_W-1:0]  held_off_d;
	logic [NLEN_W-1:0] held_len_d;

	// Result register.
	logic              out_valid_q;
	status_t           out_status_q;
	logic [IDX_W-1:0]  out_idx_q;
	logic [OFF_W-1:0]  out_noff_q;
	logic [NLEN_W-1:0] out_nlen_q;
	logic [OFF_W-1:0]  out_doff_q;
	logic [OFF_W-1:0]  out_dlen_q;

	logic              res_hit;
	status_t           res_status;
	logic [IDX_W-1:0]  res_idx;
	logic [OFF_W-1:0]  res_noff;
	logic [NLEN_W-1:0] res_nlen;
	logic [OFF_W-1:0]  res_doff;
	logic [OFF_W-1:0]  res_dlen;

	// Shared decode of the current byte.
	logic              step_go;
	logic [3:0]        need;
	logic [3:0]        fcnt_inc;
	logic              field_done;
	logic [63:0]       shift_new;
	logic [31:0]       v32;
	logic [OFF_W-1:0]  next_pos;
	logic [NLEN_W-1:0] lim;
	logic              name_bad;
	logic [63:0]       end_sum;
	logic              data_bad;
	logic [OFF_W-1:0]  skip_dec;
	logic              skip_zero;
	logic              fin;
	logic              cnt_ok;
	logic              nlen_ok;
	logic              dlen_ok;
	logic [IDX_W-1:0]  cur_after;

	// A byte moves on when the result register can take whatever it yields.
	assign advance = step.valid && (!out_valid_q || entry.ready);
	assign step_go = advance;

	assign need       = (phase_q == PH_DATALEN) ? LONG_FIELD_BYTES : SHORT_FIELD_BYTES;
	assign fcnt_inc   = {1'b0, fcnt_q} + 4'd1;
	assign field_done = (fcnt_inc >= need);
	assign shift_new  = {shift_q[55:0], step.data};
	assign v32        = shift_new[31:0];
	assign next_pos   = pos_q + {{(OFF_W-1){1'b0}}, 1'b1};

	// Name length must be nonzero, positive and within the active limit.
	assign lim      = (max_name_len > NAME_LIMIT) ? NAME_LIMIT : max_name_len;
	assign name_bad = (v32 == 32'd0) || v32[31] || (v32 > {{(32-NLEN_W){1'b0}}, lim});

	// Data length must not be negative and its end offset must fit in 63 bits.
	assign end_sum  = {1'b0, next_pos} + {1'b0, shift_new[62:0]};
	assign data_bad = shift_new[63] || end_sum[63];

	assign skip_dec  = skip_q - {{(OFF_W-1){1'b0}}, 1'b1};
	assign skip_zero = (skip_dec == '0);
	assign fin       = (entries_q <= {{(IDX_W-1){1'b0}}, 1'b1});

	assign cnt_ok  = (phase_q == PH_COUNT) && field_done && !v32[31] && (v32 != 32'd0);
	assign nlen_ok = (phase_q == PH_NAMELEN) && field_done && !name_bad;
	assign dlen_ok = (phase_q == PH_DATALEN) && field_done && !data_bad;
	assign cur_after = dlen_ok ? cur_q + {{(IDX_W-1){1'b0}}, 1'b1} : cur_q;

	// Next phase.
	always_comb begin
		phase_after = phase_q;
		case (phase_q)
			PH_COUNT: begin
				if (field_done) begin
					phase_after = cnt_ok ? PH_NAMELEN : PH_DONE;
				end
			end
			PH_NAMELEN: begin
				if (field_done) begin
					phase_after = name_bad ? PH_DONE : PH_NAME;
				end
			end
			PH_NAME: begin
				if (skip_zero) begin
					phase_after = PH_DATALEN;
				end
			end
			PH_DATALEN: begin
				if (field_done) begin
					if (data_bad || fin) begin
						phase_after = PH_DONE;
					end else if (shift_new == 64'd0) begin
						phase_after = PH_NAMELEN;
					end else begin
						phase_after = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				if (skip_zero) begin
					phase_after = PH_NAMELEN;
				end
			end
			default: begin
				phase_after = phase_q;
			end
		endcase
		phase_d = step.last ? PH_COUNT : phase_after;
	end

	// Result of the current byte.
	always_comb begin
		res_hit    = 1'b0;
		res_status = ST_ENTRY;
		res_idx    = cur_q;
		res_noff   = '0;
		res_nlen   = '0;
		res_doff   = '0;
		res_dlen   = '0;
		case (phase_q)
			PH_COUNT: begin
				if (field_done && v32[31]) begin
					res_hit    = 1'b1;
					res_status = ST_NEG_COUNT;
				end else if (field_done && (v32 == 32'd0)) begin
					res_hit    = 1'b1;
					res_status = ST_EMPTY;
					res_idx    = '0;
				end
			end
			PH_NAMELEN: begin
				if (field_done && name_bad) begin
					res_hit    = 1'b1;
					res_status = ST_BAD_NAME;
				end
			end
			PH_DATALEN: begin
				if (field_done && data_bad) begin
					res_hit    = 1'b1;
					res_status = ST_BAD_DATA;
				end else if (field_done) begin
					res_hit    = 1'b1;
					res_status = fin ? ST_FINAL : ST_ENTRY;
					res_noff   = held_off_q;
					res_nlen   = held_len_q;
					res_doff   = next_pos;
					res_dlen   = shift_new[62:0];
				end
			end
			default: begin
				res_hit = 1'b0;
			end
		endcase
		// A stream that ends before the directory is complete overrides all else.
		if (step.last && (phase_after != PH_DONE)) begin
			res_hit    = 1'b1;
			res_status = ST_TRUNC;
			res_idx    = cur_after;
			res_noff   = '0;
			res_nlen   = '0;
			res_doff   = '0;
			res_dlen   = '0;
		end
	end

	// Counters, accumulator and held name fields.
	always_comb begin
		fcnt_d     = fcnt_q;
		shift_d    = shift_q;
		entries_d  = entries_q;
		cur_d      = cur_q;
		skip_d     = skip_q;
		held_off_d = held_off_q;
		held_len_d = held_len_q;
		case (phase_q)
			PH_COUNT, PH_NAMELEN, PH_DATALEN: begin
				fcnt_d  = field_done ? 3'd0 : fcnt_inc[2:0];
				shift_d = field_done ? 64'd0 : shift_new;
			end
			PH_NAME, PH_PAYLOAD: begin
				skip_d = skip_dec;
			end
			default: begin
				fcnt_d = fcnt_q;
			end
		endcase
		if (cnt_ok) begin
			entries_d = v32[IDX_W-1:0];
			cur_d     = '0;
		end
		if (nlen_ok) begin
			held_len_d = v32[NLEN_W-1:0];
			held_off_d = next_pos;
			skip_d     = {{(OFF_W-32){1'b0}}, v32};
		end
		if (dlen_ok) begin
			entries_d = entries_q - {{(IDX_W-1){1'b0}}, 1'b1};
			cur_d     = cur_after;
			if (!fin && (shift_new != 64'd0)) begin
				skip_d = shift_new[62:0];
			end
		end
		// The stream-end byte returns the walker to its starting point.
		if (step.last) begin
			fcnt_d     = '0;
			shift_d    = '0;
			entries_d  = '0;
			cur_d      = '0;
			skip_d     = '0;
			held_off_d = '0;
			held_len_d = '0;
		end
	end

	// State registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_COUNT;
			fcnt_q     <= '0;
			shift_q    <= '0;
			entries_q  <= '0;
			cur_q      <= '0;
			pos_q      <= '0;
			skip_q     <= '0;
			held_off_q <= '0;
			held_len_q <= '0;
		end else if (step_go) begin
			phase_q    <= phase_d;
			fcnt_q     <= fcnt_d;
			shift_q    <= shift_d;
			entries_q  <= entries_d;
			cur_q      <= cur_d;
			pos_q      <= step.last ? '0 : next_pos;
			skip_q     <= skip_d;
			held_off_q <= held_off_d;
			held_len_q <= held_len_d;
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step_go && res_hit) begin
			out_valid_q <= 1'b1;
		end else if (entry.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (step_go && res_hit) begin
			out_status_q <= res_status;
			out_idx_q    <= res_idx;
			out_noff_q   <= res_noff;
			out_nlen_q   <= res_nlen;
			out_doff_q   <= res_doff;
			out_dlen_q   <= res_dlen;
		end
	end

	assign entry.valid          = out_valid_q;
	assign entry.status         = out_status_q;
	assign entry.entry_index    = out_idx_q;
	assign entry.name_offset    = out_noff_q;
	assign entry.name_length    = out_nlen_q;
	assign entry.payload_offset = out_doff_q;
	assign entry.data_length    = out_dlen_q;

	// The stream-end byte leaves the walker at the start of a new archive.
	`ADP_ASSERT_NXT(a_end_clears, clk, arst_n, step_go && step.last, (phase_q == PH_COUNT) && (pos_q == '0))
	// Once the directory is finished no byte produces a result.
	`ADP_ASSERT_IMP(a_done_silent, clk, arst_n, step_go && (phase_q == PH_DONE), !res_hit)
	// Four-byte fields never count past their length.
	`ADP_ASSERT_IMP(a_short_field, clk, arst_n, (phase_q == PH_COUNT) || (phase_q == PH_NAMELEN), fcnt_q < 3'd4)
	// Descriptors always carry a nonzero name length.
	`ADP_ASSERT_IMP(a_desc_name, clk, arst_n, out_valid_q && ((out_status_q == ST_ENTRY) || (out_status_q == ST_FINAL)), out_nlen_q != '0)

endmodule

/* bench/archive_directory_parser_core_tb.sv */
// Testbench for the archive directory parser: directed and random archives checked byte by byte.
module archive_directory_parser_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import adp_pkg::*;

	// One descriptor or error report as it leaves the block.
	typedef struct packed {
		status_t           status;
		logic [IDX_W-1:0]  entry_index;
		logic [OFF_W-1:0]  name_offset;
		logic [NLEN_W-1:0] name_length;
		logic [OFF_W-1:0]  payload_offset;
		logic [OFF_W-1:0]  data_length;
	} entry_t;

	// One stream byte, with an optional expectation typed in by hand.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       typed;
		entry_t     want;
	} byte_item_t;

	typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_t;

	localparam logic [63:0] OFFSET_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam int PHASES = 8;
	localparam int PHASE_BYTES = 175;
	localparam int DRAIN_CYCLES = 6;

	// Hand-computed results of the directed archives.
	localparam entry_t NO_ENTRY = '0;
	localparam entry_t WANT_EMPTY = '{ST_EMPTY, 31'd0, 63'd0, 21'd0, 63'd0, 63'd0};
	localparam entry_t WANT_NEG = '{ST_NEG_COUNT, 31'd0, 63'd0, 21'd0, 63'd0, 63'd0};
	localparam entry_t WANT_TRUNC = '{ST_TRUNC, 31'd0, 63'd0, 21'd0, 63'd0, 63'd0};
	localparam entry_t WANT_FIRST = '{ST_ENTRY, 31'd0, 63'd8, 21'd1, 63'd17, 63'd0};
	localparam entry_t WANT_BAD_NAME = '{ST_BAD_NAME, 31'd1, 63'd0, 21'd0, 63'd0, 63'd0};

	localparam int DIR_ROWS = 30;
	localparam byte_item_t DIRECTED [DIR_ROWS] = '{
		// Empty archive: a zero entry count ending the stream.
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b1, 1'b1, WANT_EMPTY},
		// An all-ones count is negative.
		'{8'hFF, 1'b0, 1'b0, NO_ENTRY},
		'{8'hFF, 1'b0, 1'b0, NO_ENTRY},
		'{8'hFF, 1'b0, 1'b0, NO_ENTRY},
		'{8'hFF, 1'b1, 1'b1, WANT_NEG},
		// Stream end on the very first byte.
		'{8'h00, 1'b1, 1'b1, WANT_TRUNC},
		// Two entries: a one-byte name with empty payload, then a zero name length.
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h02, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h01, 1'b0, 1'b0, NO_ENTRY},
		'{8'h7E, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b1, WANT_FIRST},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b0, 1'b0, NO_ENTRY},
		'{8'h00, 1'b1, 1'b1, WANT_BAD_NAME}
	};

	logic              clk;
	logic              arst_n;
	logic              cfg_wr_en;
	logic [NLEN_W-1:0] cfg_wr_data;

	adp_stream_if stream_bus ();
	adp_entry_if  entry_bus ();

	archive_directory_parser_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.stream      (stream_bus),
		.entry       (entry_bus),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	// Directory walker state, kept in step with the accepted bytes.
	phase_t            walk_phase;
	logic [3:0]        walk_fill;
	logic [63:0]       walk_shift;
	logic [IDX_W-1:0]  walk_left;
	logic [IDX_W-1:0]  walk_entry;
	logic [OFF_W-1:0]  walk_pos;
	logic [OFF_W-1:0]  walk_skip;
	logic [OFF_W-1:0]  walk_name_off;
	logic [NLEN_W-1:0] walk_name_len;
	logic [NLEN_W-1:0] max_name_len;

	byte_item_t byte_queue [$];
	entry_t     expected_entries [$];
	logic [7:0] arc_bytes [$];
	byte_item_t held_item;
	entry_t     walked;
	entry_t     oldest;

	int sender_rest_pct;
	int stall_pct;
	int mismatches;
	int bytes_taken;
	int archives;
	int status_seen [7];

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_walk();
		walk_phase = PH_COUNT;
		walk_fill = '0;
		walk_shift = '0;
		walk_left = '0;
		walk_entry = '0;
		walk_pos = '0;
		walk_skip = '0;
		walk_name_off = '0;
		walk_name_len = '0;
	endfunction

	// Shifts one byte into the header accumulator; true when the field is complete.
	function automatic bit shift_field(input logic [7:0] b, input logic [3:0] need);
		walk_shift = {walk_shift[55:0], b};
		if (walk_fill + 4'd1 >= need) begin
			walk_fill = '0;
			return 1'b1;
		end
		walk_fill = walk_fill + 4'd1;
		return 1'b0;
	endfunction

	// Advances the walker by one byte; true when the byte yields a result.
	function automatic bit walk_byte(input logic [7:0] b, input logic last, output entry_t res);
		logic [OFF_W-1:0]  next_pos;
		logic [63:0]       v;
		logic [63:0]       reach;
		logic [NLEN_W-1:0] lim;
		status_t           fault;
		bit                failed;
		bit                got;
		bit                fin;
		next_pos = walk_pos + 63'd1;
		res = '0;
		got = 1'b0;
		failed = 1'b0;
		fault = ST_ENTRY;
		case (walk_phase)
		PH_COUNT: begin
			if (shift_field(b, SHORT_FIELD_BYTES)) begin
				v = {32'd0, walk_shift[31:0]};
				walk_shift = '0;
				if (v[31]) begin
					failed = 1'b1;
					fault = ST_NEG_COUNT;
				end else if (v == 0) begin
					res.status = ST_EMPTY;
					got = 1'b1;
					walk_phase = PH_DONE;
				end else begin
					walk_left = v[30:0];
					walk_entry = '0;
					walk_phase = PH_NAMELEN;
				end
			end
		end
		PH_NAMELEN: begin
			if (shift_field(b, SHORT_FIELD_BYTES)) begin
				v = {32'd0, walk_shift[31:0]};
				walk_shift = '0;
				lim = (max_name_len > NAME_LIMIT) ? NAME_LIMIT : max_name_len;
				if (v == 0 || v[31] || v > lim) begin
					failed = 1'b1;
					fault = ST_BAD_NAME;
				end else begin
					walk_name_len = v[NLEN_W-1:0];
					walk_name_off = next_pos;
					walk_skip = v[OFF_W-1:0];
					walk_phase = PH_NAME;
				end
			end
		end
		PH_NAME: begin
			walk_skip = walk_skip - 63'd1;
			if (walk_skip == 0)
				walk_phase = PH_DATALEN;
		end
		PH_DATALEN: begin
			if (shift_field(b, LONG_FIELD_BYTES)) begin
				v = walk_shift;
				walk_shift = '0;
				reach = {1'b0, next_pos} + v;
				if (v[63] || reach[63]) begin
					failed = 1'b1;
					fault = ST_BAD_DATA;
				end else begin
					fin = (walk_left <= 1);
					res = '{fin ? ST_FINAL : ST_ENTRY, walk_entry, walk_name_off,
						walk_name_len, next_pos, v[OFF_W-1:0]};
					got = 1'b1;
					walk_left = walk_left - 31'd1;
					walk_entry = walk_entry + 31'd1;
					if (fin) begin
						walk_phase = PH_DONE;
					end else if (v == 0) begin
						walk_phase = PH_NAMELEN;
					end else begin
						walk_skip = v[OFF_W-1:0];
						walk_phase = PH_PAYLOAD;
					end
				end
			end
		end
		PH_PAYLOAD: begin
			walk_skip = walk_skip - 63'd1;
			if (walk_skip == 0)
				walk_phase = PH_NAMELEN;
		end
		default: begin
		end
		endcase

		// Errors report the entry in progress and end the directory.
		if (failed) begin
			res = '{fault, walk_entry, 63'd0, 21'd0, 63'd0, 63'd0};
			got = 1'b1;
			walk_phase = PH_DONE;
		end
		walk_pos = next_pos;

		// A stream end before the directory is done overrides any descriptor.
		if (last) begin
			if (walk_phase != PH_DONE) begin
				res = '{ST_TRUNC, walk_entry, 63'd0, 21'd0, 63'd0, 63'd0};
				got = 1'b1;
			end
			clear_walk();
		end
		return got;
	endfunction

	function automatic void put_field(input logic [63:0] v, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			arc_bytes.insert(arc_bytes.size(), v[8*i +: 8]);
	endfunction

	function automatic void put_noise(input int n);
		repeat (n) arc_bytes.insert(arc_bytes.size(), 8'($urandom));
	endfunction

	// Builds one archive, mostly well formed, with errors and early ends mixed in.
	function automatic void build_archive();
		logic [31:0]       count;
		logic [31:0]       nlen;
		logic [63:0]       dlen;
		logic [63:0]       doff;
		logic [NLEN_W-1:0] lim;
		int unsigned       n_emit;
		int unsigned       len;
		int unsigned       pick;
		bit                stop;
		bit                fin;
		arc_bytes.delete();
		lim = (max_name_len > NAME_LIMIT) ? NAME_LIMIT : max_name_len;
		if ($urandom_range(99) < 5) begin
			put_noise($urandom_range(10, 1));
		end else begin
			pick = $urandom_range(99);
			if (pick < 85)
				count = $urandom_range(4, 1);
			else if (pick < 90)
				count = 0;
			else if (pick < 95)
				count = 32'h8000_0000 | $urandom;
			else
				count = $urandom_range(32'h7FFF_FFFF, 5);
			put_field(64'(count), 4);
			stop = (count == 0) || count[31];
			n_emit = (count > 4) ? $urandom_range(3, 1) : count;
			for (int e = 0; e < n_emit && !stop; e++) begin
				fin = (e == count - 1);

				// Name length: mostly short and legal, sometimes at or past the limit.
				pick = $urandom_range(99);
				if (pick < 80)
					nlen = $urandom_range((lim == 0 || lim > 6) ? 6 : lim, 1);
				else if (pick < 85)
					nlen = 0;
				else if (pick < 90)
					nlen = lim + 1;
				else if (pick < 94)
					nlen = 32'h8000_0000 | $urandom;
				else
					nlen = (lim == 0) ? 1 : lim;
				put_field(64'(nlen), 4);
				if (nlen == 0 || nlen[31] || nlen > lim) begin
					stop = 1'b1;
				end else if (nlen > 40) begin
					put_noise($urandom_range(5, 1));
					stop = 1'b1;
				end else begin
					put_noise(nlen);
				end

				// Data length: mostly short, sometimes negative or at the offset limit.
				if (!stop) begin
					doff = 64'(arc_bytes.size() + 8);
					pick = $urandom_range(99);
					if (pick < 75)
						dlen = 64'($urandom_range(5));
					else if (pick < 83)
						dlen = {1'b1, 31'($urandom), 32'($urandom)};
					else if (pick < 90)
						dlen = OFFSET_MAX - doff + 1 + $urandom_range(3);
					else if (pick < 95)
						dlen = OFFSET_MAX - doff;
					else
						dlen = {1'b0, 31'($urandom), 32'($urandom)};
					put_field(dlen, 8);
					if (dlen[63] || doff + dlen > OFFSET_MAX) begin
						stop = 1'b1;
					end else if (!fin) begin
						if (dlen > 40) begin
							put_noise($urandom_range(5, 1));
							stop = 1'b1;
						end else begin
							put_noise(int'(dlen));
						end
					end
				end
			end
			put_noise($urandom_range(3));
		end

		// Sometimes the stream ends early at a random byte.
		len = arc_bytes.size();
		if ($urandom_range(99) < 20)
			len = $urandom_range(len, 1);
		for (int i = 0; i < len; i++)
			byte_queue.insert(byte_queue.size(),
				'{arc_bytes[i], i == len - 1, 1'b0, NO_ENTRY});
		archives++;
	endfunction

	function automatic void check_field(input string what, input logic [63:0] want,
		input logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	// Request side: present queued bytes and predict each one as it is taken.
	always @(posedge clk) begin
		if (stream_bus.valid && stream_bus.ready) begin
			if (walk_byte(stream_bus.data_byte, stream_bus.stream_end, walked)
				&& !held_item.typed)
				expected_entries.insert(expected_entries.size(), walked);
			if (held_item.typed)
				expected_entries.insert(expected_entries.size(), held_item.want);
			bytes_taken++;
		end
		if (!stream_bus.valid || stream_bus.ready) begin
			if (byte_queue.size() != 0 && $urandom_range(99) >= sender_rest_pct) begin
				held_item = byte_queue.pop_front();
				stream_bus.valid <= 1'b1;
				stream_bus.data_byte <= held_item.data;
				stream_bus.stream_end <= held_item.last;
			end else begin
				stream_bus.valid <= 1'b0;
			end
		end
	end

	// Result side: compare each taken result with the oldest expectation.
	always @(posedge clk) begin
		if (entry_bus.valid && entry_bus.ready) begin
			if (expected_entries.size() == 0) begin
				$display("%0t: expected no result, actual status %0d index %0d", $time,
					entry_bus.status, entry_bus.entry_index);
				mismatches++;
			end else begin
				oldest = expected_entries.pop_front();
				check_field("status", 64'(oldest.status), 64'(entry_bus.status));
				check_field("entry_index", 64'(oldest.entry_index),
					64'(entry_bus.entry_index));
				check_field("name_offset", 64'(oldest.name_offset),
					64'(entry_bus.name_offset));
				check_field("name_length", 64'(oldest.name_length),
					64'(entry_bus.name_length));
				check_field("payload_offset", 64'(oldest.payload_offset),
					64'(entry_bus.payload_offset));
				check_field("data_length", 64'(oldest.data_length),
					64'(entry_bus.data_length));
				status_seen[oldest.status]++;
			end
		end
		entry_bus.ready <= ($urandom_range(99) >= stall_pct);
	end

	// Waits until every byte is taken and every result has come, then lets the pipeline drain.
	task automatic wait_drained();
		while (byte_queue.size() != 0 || stream_bus.valid || expected_entries.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Main sequence: reset, directed archives, then random phases per register setting.
	initial begin
		logic [NLEN_W-1:0] phase_limit [PHASES];
		idle_t             phase_idle [PHASES];
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		stream_bus.valid = 1'b0;
		stream_bus.data_byte = '0;
		stream_bus.stream_end = 1'b0;
		entry_bus.ready = 1'b0;
		held_item = '0;
		sender_rest_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		bytes_taken = 0;
		archives = 4;
		foreach (status_seen[i])
			status_seen[i] = 0;
		max_name_len = NAME_LIMIT;
		clear_walk();

		phase_limit = '{NAME_LIMIT, 21'd6, 21'd1, 21'h1F_FFFF, 21'd0, 21'd1048575,
			21'($urandom_range(40, 2)), NAME_LIMIT};
		phase_idle = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH, IDLE_SENDER,
			IDLE_RECEIVER, IDLE_BOTH, IDLE_NONE};

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed archives at the reset value of the name limit.
		@(negedge clk);
		for (int i = 0; i < DIR_ROWS; i++)
			byte_queue.insert(byte_queue.size(), DIRECTED[i]);
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			cfg_wr_en <= 1'b1;
			cfg_wr_data <= phase_limit[p];
			max_name_len = phase_limit[p];
			@(posedge clk);
			cfg_wr_en <= 1'b0;
			case (phase_idle[p])
			IDLE_NONE: begin
				sender_rest_pct = 0;
				stall_pct = 0;
			end
			IDLE_SENDER: begin
				sender_rest_pct = 67;
				stall_pct = 0;
			end
			IDLE_RECEIVER: begin
				sender_rest_pct = 0;
				stall_pct = 67;
			end
			default: begin
				sender_rest_pct = 36;
				stall_pct = 36;
			end
			endcase
			@(negedge clk);
			while (byte_queue.size() < PHASE_BYTES)
				build_archive();
			wait_drained();
		end

		$display("Walked %0d archives (%0d bytes): directed cases, then %0d random phases.",
			archives, bytes_taken, PHASES);
		$display("Results: %0d entry, %0d final, %0d empty, %0d neg count, %0d bad name, %0d bad data, %0d truncated.",
			status_seen[ST_ENTRY], status_seen[ST_FINAL], status_seen[ST_EMPTY],
			status_seen[ST_NEG_COUNT], status_seen[ST_BAD_NAME], status_seen[ST_BAD_DATA],
			status_seen[ST_TRUNC]);
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Run limit, far beyond the slowest correct run.
	initial begin
		#5ms;
		$display("FAILURE");
		$finish;
	end

endmodule

/* filelist.f */
+incdir+rtl
rtl/adp_pkg.sv
rtl/adp_stream_if.sv
rtl/adp_entry_if.sv
rtl/adp_in_stage.sv
rtl/adp_walker.sv
rtl/archive_directory_parser_core.sv
bench/archive_directory_parser_core_tb.sv
